// File: hdl/rytg_pkg.sv
// Shared types and constant tables for the rotary table generator.
// Holds the unit request/response structs, register indexes, the exp2 root table and the
// CORDIC angle table. No dependencies.
package rytg_pkg;

  typedef logic [31:0] rytg_ck_arr_t [17];
  typedef logic [31:0] rytg_atan_arr_t [24];

  typedef struct packed {
    logic        go;
    logic [5:0]  nbits;
    logic [47:0] dividend;
    logic [31:0] divisor;
  } rytg_div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quo;
    logic [31:0] rem;
  } rytg_div_rsp_t;

  typedef struct packed {
    logic        go;
    logic [63:0] a;
    logic [63:0] b;
  } rytg_mul_req_t;

  typedef struct packed {
    logic        done;
    logic [95:0] prod;
  } rytg_mul_rsp_t;

  // configuration register indexes
  localparam logic [2:0] REG_LOG2_BASE    = 3'd0;
  localparam logic [2:0] REG_HEAD_WIDTH   = 3'd1;
  localparam logic [2:0] REG_SCALING_ON   = 3'd2;
  localparam logic [2:0] REG_SCALE_FACTOR = 3'd3;
  localparam logic [2:0] REG_FAST_BETA    = 3'd4;
  localparam logic [2:0] REG_SLOW_BETA    = 3'd5;

  localparam logic [63:0] INV_TWO_PI_Q64  = 64'h28BE60DB9391054A;
  localparam logic [31:0] HALF_PI_Q30     = 32'h6487ED51;
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'h26DD3B6A;
  localparam logic [16:0] ONE_Q16         = 17'h10000;

  localparam rytg_atan_arr_t ATAN_Q30 = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F};

  // Successive square roots of one half in Q.32: entry k is 2^(-1/2^k).
  function automatic rytg_ck_arr_t build_ck();
    rytg_ck_arr_t c;
    logic [63:0]  n;
    logic [63:0]  res;
    logic [63:0]  bit_v;
    c[0] = 32'h8000_0000;
    for (int k = 1; k <= 16; k++) begin
      n     = {c[k-1], 32'h0};
      res   = 64'h0;
      bit_v = 64'h1 << 62;
      for (int j = 0; j < 32; j++) begin
        if (n >= res + bit_v) begin
          n   = n - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
      c[k] = res[31:0];
    end
    return c;
  endfunction

  localparam rytg_ck_arr_t EXP2_CK = build_ck();

endpackage

// File: hdl/rytg_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rytg_pkg for its request and response structs.
module rytg_divider (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rytg_pkg::rytg_div_req_t req,
  output rytg_pkg::rytg_div_rsp_t rsp
);

  logic [47:0] dvd_r;
  logic [31:0] dsr_r;
  logic [31:0] rem_r;
  logic [47:0] quo_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] rem2;
  logic        fits;

  assign rem2 = {rem_r, dvd_r[47]};
  assign fits = rem2 >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        // left-align the dividend so that only nbits steps run
        dvd_r  <= req.dividend << (6'd48 - req.nbits);
        dsr_r  <= req.divisor;
        rem_r  <= '0;
        quo_r  <= '0;
        cnt_r  <= req.nbits;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? 32'(rem2 - {1'b0, dsr_r}) : rem2[31:0];
        quo_r <= {quo_r[46:0], fits};
        dvd_r <= {dvd_r[46:0], 1'b0};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// File: hdl/rytg_multiplier.sv
// Sequential 64x64 multiplier built from four registered 32x32 partial products.
// Depends on rytg_pkg for its request and response structs; keeps the low 96 product bits.
module rytg_multiplier (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rytg_pkg::rytg_mul_req_t req,
  output rytg_pkg::rytg_mul_rsp_t rsp
);

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] p_r;
  logic [1:0]  sh_r;
  logic [95:0] acc_r;
  logic [2:0]  idx_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] a_sel;
  logic [31:0] b_sel;
  logic [95:0] p_shifted;

  assign a_sel     = idx_r[1] ? a_r[63:32] : a_r[31:0];
  assign b_sel     = idx_r[0] ? b_r[63:32] : b_r[31:0];
  assign p_shifted = {32'h0, p_r} << {sh_r, 5'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        a_r    <= req.a;
        b_r    <= req.b;
        acc_r  <= '0;
        idx_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (idx_r != 3'd4) begin
          p_r  <= a_sel * b_sel;
          sh_r <= 2'(idx_r[1]) + 2'(idx_r[0]);
        end
        // accumulate the product registered in the previous cycle
        if (idx_r != 3'd0) begin
          acc_r <= acc_r + p_shifted;
        end
        if (idx_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

// File: hdl/rytg_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, with quadrant fold-out.
// Depends on rytg_pkg for the angle table and gain; rounds and saturates the results.
module rytg_cordic #(
  parameter int CORDIC_STEPS  = 16,
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [30:0] z_in,
  input  logic [1:0]  quad,
  output logic        done,
  output logic [15:0] cos_o,
  output logic [15:0] sin_o
);

  localparam int STEPS  = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int RSHIFT = 30 - OUT_FRAC_BITS;

  logic signed [33:0] x_r;
  logic signed [33:0] y_r;
  logic signed [33:0] z_r;
  logic [1:0]         q_r;
  logic [4:0]         k_r;
  logic               busy_r;
  logic               done_r;
  logic [15:0]        cos_r;
  logic [15:0]        sin_r;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] at;
  logic signed [33:0] cs;
  logic signed [33:0] sn;

  function automatic logic [15:0] to_out(input logic signed [33:0] v);
    logic signed [34:0] s;
    logic signed [34:0] hi;
    logic signed [34:0] lo;
    s  = (35'(v) + (35'sd1 <<< (RSHIFT - 1))) >>> RSHIFT;
    hi = (35'sd1 <<< OUT_FRAC_BITS) - 35'sd1;
    lo = -(35'sd1 <<< OUT_FRAC_BITS);
    if (s > hi) s = hi;
    if (s < lo) s = lo;
    return s[15:0];
  endfunction

  assign xs = x_r >>> k_r;
  assign ys = y_r >>> k_r;
  assign at = $signed({2'b00, rytg_pkg::ATAN_Q30[k_r]});

  always_comb begin
    case (q_r)
      2'd0:    begin cs = x_r;  sn = y_r;  end
      2'd1:    begin cs = -y_r; sn = x_r;  end
      2'd2:    begin cs = -x_r; sn = -y_r; end
      default: begin cs = y_r;  sn = -x_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        x_r    <= $signed(34'(rytg_pkg::CORDIC_GAIN_Q30));
        y_r    <= '0;
        z_r    <= $signed(34'(z_in));
        q_r    <= quad;
        k_r    <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (k_r == 5'(STEPS)) begin
          cos_r  <= to_out(cs);
          sin_r  <= to_out(sn);
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          if (!z_r[33]) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + at;
          end
          k_r <= k_r + 5'd1;
        end
      end
    end
  end

  assign done  = done_r;
  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

// File: hdl/rope_yarn_table_generator.sv
// Rotary position table row generator: top level with sequencer and shared units.
// Depends on rytg_pkg, rytg_divider, rytg_multiplier and rytg_cordic.
//
// Takes one token position per transaction and returns one result transaction per rotary
// pair (head_width/2 pairs, capped at MAX_HEAD_WIDTH/2 and at 64): the pair index, cos
// and sin of position times the pair's inverse frequency in Q1.15, and a last-pair flag.
// The block works on one position at a time and holds in_stall high until the last pair
// of the row has been taken. Per position one divide sets up the exponent step, and two
// more set the ramp edges when scaling is on. Each pair then walks the 16-bit fraction of
// its exponent, with one multiply per set bit (exp2 by multiplication with root constants),
// then runs three multiplies, the CORDIC and the output handshake; scaling on adds a scale
// divide, a ramp divide where the ramp needs one, and two multiplies. The row time is set
// by the shared bit-serial divider and the four-pass multiplier.
module rope_yarn_table_generator #(
  parameter int MAX_HEAD_WIDTH = 128,
  parameter int POSITION_BITS  = 16,
  parameter int CORDIC_STEPS   = 16,
  parameter int OUT_FRAC_BITS  = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_pair_index,
  output logic [15:0] out_cos_value,
  output logic [15:0] out_sin_value,
  output logic        out_last_pair,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int PAIR_CAP = (MAX_HEAD_WIDTH / 2 < 64) ? MAX_HEAD_WIDTH / 2 : 64;
  localparam int POS_KEEP = (POSITION_BITS < 16) ? POSITION_BITS : 16;
  localparam logic [15:0] POS_MASK = 16'((17'd1 << POS_KEEP) - 17'd1);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DIV_T  = 5'd1;
  localparam logic [4:0] S_DIV_LO = 5'd2;
  localparam logic [4:0] S_DIV_HI = 5'd3;
  localparam logic [4:0] S_EXP    = 5'd4;
  localparam logic [4:0] S_EXP_W  = 5'd5;
  localparam logic [4:0] S_SHIFT  = 5'd6;
  localparam logic [4:0] S_DIV_SC = 5'd7;
  localparam logic [4:0] S_RAMP   = 5'd8;
  localparam logic [4:0] S_DIV_R  = 5'd9;
  localparam logic [4:0] S_MA_W   = 5'd10;
  localparam logic [4:0] S_MB_W   = 5'd11;
  localparam logic [4:0] S_ANG_W  = 5'd12;
  localparam logic [4:0] S_TURN_W = 5'd13;
  localparam logic [4:0] S_Z_W    = 5'd14;
  localparam logic [4:0] S_COR_W  = 5'd15;
  localparam logic [4:0] S_OUT    = 5'd16;

  // configuration registers
  logic [23:0] log2_base_r;
  logic [7:0]  head_width_r;
  logic        scaling_on_r;
  logic [15:0] scale_factor_r;
  logic [15:0] fast_beta_r;
  logic [15:0] slow_beta_r;

  // sequencer and per-row state
  logic [4:0]  state_r;
  logic [15:0] pos_r;
  logic [5:0]  i_r;
  logic [23:0] q0_r;
  logic [6:0]  r0_r;
  logic [23:0] tq_r;
  logic [6:0]  tr_r;
  logic [31:0] lo_r;
  logic [31:0] hi_r;
  logic [32:0] v_r;
  logic [4:0]  kk_r;
  logic [32:0] inv_r;
  logic [40:0] scaled_r;
  logic [16:0] r_r;
  logic [57:0] sum_r;
  logic [1:0]  quad_r;
  logic        out_valid_r;
  logic [5:0]  out_pair_index_r;
  logic [15:0] out_cos_r;
  logic [15:0] out_sin_r;
  logic        out_last_r;

  rytg_pkg::rytg_div_req_t div_req_r;
  rytg_pkg::rytg_div_rsp_t div_rsp;
  rytg_pkg::rytg_mul_req_t mul_req_r;
  rytg_pkg::rytg_mul_rsp_t mul_rsp;
  logic                    cor_go_r;
  logic [30:0]             cor_z_r;
  logic                    cor_done;
  logic [15:0]             cor_cos;
  logic [15:0]             cor_sin;

  // derived combinational values
  logic [6:0]         pairs_raw;
  logic [6:0]         pairs;
  logic [7:0]         hw8;
  logic [15:0]        sf;
  logic [15:0]        bf;
  logic [15:0]        bs;
  logic [15:0]        g_w;
  logic [3:0]         gidx;
  logic [7:0]         n_w;
  logic [32:0]        inv_w;
  logic [22:0]        d_w;
  logic signed [33:0] num_s;
  logic signed [33:0] den_s;
  logic [33:0]        num_abs;
  logic [33:0]        den_abs;
  logic [7:0]         tr_sum;
  logic               tr_carry;
  logic               last_w;

  assign pairs_raw = head_width_r[7:1];
  assign pairs     = (pairs_raw > 7'(PAIR_CAP)) ? 7'(PAIR_CAP) : pairs_raw;
  assign hw8       = {pairs, 1'b0};
  // zero factor means one, zero beta means the smallest step
  assign sf        = (scale_factor_r == 16'd0) ? 16'd256 : scale_factor_r;
  assign bf        = (fast_beta_r == 16'd0) ? 16'd1 : fast_beta_r;
  assign bs        = (slow_beta_r == 16'd0) ? 16'd1 : slow_beta_r;

  // exponent t = floor(log2_base * i / pairs): integer part shifts, fraction multiplies
  assign g_w   = tq_r[15:0];
  assign gidx  = 4'(5'd16 - kk_r);
  assign n_w   = tq_r[23:16];
  assign inv_w = (n_w >= 8'd33) ? 33'd0 : (v_r >> n_w);

  // ramp over the dimension index 2i, in Q.16
  assign d_w     = {i_r, 17'd0};
  assign num_s   = $signed(34'(d_w)) - $signed(34'(lo_r));
  assign den_s   = $signed(34'(hi_r)) - $signed(34'(lo_r));
  assign num_abs = num_s[33] ? 34'(-num_s) : 34'(num_s);
  assign den_abs = den_s[33] ? 34'(-den_s) : 34'(den_s);

  assign tr_sum   = 8'(tr_r) + 8'(r0_r);
  assign tr_carry = tr_sum >= 8'(pairs);
  assign last_w   = {1'b0, i_r} == (pairs - 7'd1);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_base_r    <= 24'd870823;
      head_width_r   <= 8'd64;
      scaling_on_r   <= 1'b0;
      scale_factor_r <= 16'd256;
      fast_beta_r    <= 16'd8192;
      slow_beta_r    <= 16'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rytg_pkg::REG_LOG2_BASE:    log2_base_r    <= cfg_data;
        rytg_pkg::REG_HEAD_WIDTH:   head_width_r   <= cfg_data[7:0];
        rytg_pkg::REG_SCALING_ON:   scaling_on_r   <= cfg_data[0];
        rytg_pkg::REG_SCALE_FACTOR: scale_factor_r <= cfg_data[15:0];
        rytg_pkg::REG_FAST_BETA:    fast_beta_r    <= cfg_data[15:0];
        rytg_pkg::REG_SLOW_BETA:    slow_beta_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      div_req_r.go <= 1'b0;
      mul_req_r.go <= 1'b0;
      cor_go_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      i_r          <= '0;
      pos_r        <= '0;
    end else begin
      // unit launches are single-cycle pulses
      div_req_r.go <= 1'b0;
      mul_req_r.go <= 1'b0;
      cor_go_r     <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          // an empty row is accepted and dropped
          if (in_valid && pairs != 7'd0) begin
            pos_r     <= in_position & POS_MASK;
            i_r       <= '0;
            tq_r      <= '0;
            tr_r      <= '0;
            div_req_r <= '{go: 1'b1, nbits: 6'd24, dividend: 48'(log2_base_r),
                           divisor: 32'(pairs)};
            state_r   <= S_DIV_T;
          end
        end
        S_DIV_T: begin
          if (div_rsp.done) begin
            q0_r <= div_rsp.quo[23:0];
            r0_r <= div_rsp.rem[6:0];
            if (scaling_on_r) begin
              div_req_r <= '{go: 1'b1, nbits: 6'd32, dividend: 48'({hw8, 24'd0}),
                             divisor: 32'(bf)};
              state_r   <= S_DIV_LO;
            end else begin
              v_r     <= 33'h1_0000_0000;
              kk_r    <= 5'd1;
              state_r <= S_EXP;
            end
          end
        end
        S_DIV_LO: begin
          if (div_rsp.done) begin
            lo_r      <= div_rsp.quo[31:0];
            div_req_r <= '{go: 1'b1, nbits: 6'd32, dividend: 48'({hw8, 24'd0}),
                           divisor: 32'(bs)};
            state_r   <= S_DIV_HI;
          end
        end
        S_DIV_HI: begin
          if (div_rsp.done) begin
            hi_r    <= div_rsp.quo[31:0];
            v_r     <= 33'h1_0000_0000;
            kk_r    <= 5'd1;
            state_r <= S_EXP;
          end
        end
        S_EXP: begin
          if (kk_r == 5'd17) begin
            state_r <= S_SHIFT;
          end else if (g_w[gidx]) begin
            mul_req_r <= '{go: 1'b1, a: 64'(v_r), b: 64'(rytg_pkg::EXP2_CK[kk_r])};
            state_r   <= S_EXP_W;
          end else begin
            kk_r <= kk_r + 5'd1;
          end
        end
        S_EXP_W: begin
          if (mul_rsp.done) begin
            v_r     <= mul_rsp.prod[64:32];
            kk_r    <= kk_r + 5'd1;
            state_r <= S_EXP;
          end
        end
        S_SHIFT: begin
          inv_r <= inv_w;
          if (scaling_on_r) begin
            div_req_r <= '{go: 1'b1, nbits: 6'd41, dividend: 48'({inv_w, 8'd0}),
                           divisor: 32'(sf)};
            state_r   <= S_DIV_SC;
          end else begin
            mul_req_r <= '{go: 1'b1, a: 64'(pos_r), b: 64'(inv_w)};
            state_r   <= S_ANG_W;
          end
        end
        S_DIV_SC: begin
          if (div_rsp.done) begin
            scaled_r <= div_rsp.quo[40:0];
            state_r  <= S_RAMP;
          end
        end
        S_RAMP: begin
          if (lo_r == hi_r) begin
            // step ramp when both edges coincide
            r_r       <= (32'(d_w) >= hi_r) ? rytg_pkg::ONE_Q16 : 17'd0;
            mul_req_r <= '{go: 1'b1, a: 64'(scaled_r),
                           b: 64'((32'(d_w) >= hi_r) ? 17'd0 : rytg_pkg::ONE_Q16)};
            state_r   <= S_MA_W;
          end else if (num_s == 34'sd0 || num_s[33] != den_s[33]) begin
            // non-positive quotient clamps to zero
            r_r       <= 17'd0;
            mul_req_r <= '{go: 1'b1, a: 64'(scaled_r), b: 64'(rytg_pkg::ONE_Q16)};
            state_r   <= S_MA_W;
          end else begin
            div_req_r <= '{go: 1'b1, nbits: 6'd48, dividend: {num_abs[31:0], 16'd0},
                           divisor: den_abs[31:0]};
            state_r   <= S_DIV_R;
          end
        end
        S_DIV_R: begin
          if (div_rsp.done) begin
            if (div_rsp.quo > 48'(rytg_pkg::ONE_Q16)) begin
              r_r       <= rytg_pkg::ONE_Q16;
              mul_req_r <= '{go: 1'b1, a: 64'(scaled_r), b: 64'd0};
            end else begin
              r_r       <= div_rsp.quo[16:0];
              mul_req_r <= '{go: 1'b1, a: 64'(scaled_r),
                             b: 64'(rytg_pkg::ONE_Q16 - div_rsp.quo[16:0])};
            end
            state_r <= S_MA_W;
          end
        end
        S_MA_W: begin
          if (mul_rsp.done) begin
            sum_r     <= mul_rsp.prod[57:0];
            mul_req_r <= '{go: 1'b1, a: 64'(inv_r), b: 64'(r_r)};
            state_r   <= S_MB_W;
          end
        end
        S_MB_W: begin
          if (mul_rsp.done) begin
            mul_req_r <= '{go: 1'b1, a: 64'(pos_r),
                           b: 64'(42'((sum_r + mul_rsp.prod[57:0]) >> 16))};
            state_r   <= S_ANG_W;
          end
        end
        S_ANG_W: begin
          if (mul_rsp.done) begin
            mul_req_r <= '{go: 1'b1, a: mul_rsp.prod[63:0], b: rytg_pkg::INV_TWO_PI_Q64};
            state_r   <= S_TURN_W;
          end
        end
        S_TURN_W: begin
          if (mul_rsp.done) begin
            // keep the angle in turns: quadrant on top, the rest to radians
            quad_r    <= mul_rsp.prod[95:94];
            mul_req_r <= '{go: 1'b1, a: 64'(mul_rsp.prod[93:64]),
                           b: 64'(rytg_pkg::HALF_PI_Q30)};
            state_r   <= S_Z_W;
          end
        end
        S_Z_W: begin
          if (mul_rsp.done) begin
            cor_z_r  <= mul_rsp.prod[60:30];
            cor_go_r <= 1'b1;
            state_r  <= S_COR_W;
          end
        end
        S_COR_W: begin
          if (cor_done) begin
            out_pair_index_r <= i_r;
            out_cos_r        <= cor_cos;
            out_sin_r        <= cor_sin;
            out_last_r       <= last_w;
            out_valid_r      <= 1'b1;
            state_r          <= S_OUT;
          end
        end
        S_OUT: begin
          // hold the result until taken, then advance to the next pair or, after the last, to idle
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              i_r     <= '0;
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + 6'd1;
              tr_r    <= tr_carry ? 7'(tr_sum - 8'(pairs)) : tr_sum[6:0];
              tq_r    <= tq_r + q0_r + 24'(tr_carry);
              v_r     <= 33'h1_0000_0000;
              kk_r    <= 5'd1;
              state_r <= S_EXP;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  rytg_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  rytg_multiplier u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req_r),
    .rsp   (mul_rsp)
  );

  rytg_cordic #(
    .CORDIC_STEPS  (CORDIC_STEPS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cor_go_r),
    .z_in  (cor_z_r),
    .quad  (quad_r),
    .done  (cor_done),
    .cos_o (cor_cos),
    .sin_o (cor_sin)
  );

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_pair_index = out_pair_index_r;
  assign out_cos_value  = out_cos_r;
  assign out_sin_value  = out_sin_r;
  assign out_last_pair  = out_last_r;

endmodule
